// ===== rtl/core/websocket_frame_deframer_top_defines.svh =====
// assertion macros shared by the websocket deframer rtl
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define WSDF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define WSDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/wsdf_pkg.sv =====
// types and constants of the websocket frame deframer
package wsdf_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 64;
  localparam int OPCODE_W   = 4;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 2;

  // 7-bit length codes that select an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // byte counts of the optional header parts
  localparam logic [LEN_W-1:0] EXT16_BYTES    = 64'd2;
  localparam logic [LEN_W-1:0] EXT64_BYTES    = 64'd8;
  localparam logic [LEN_W-1:0] MASK_KEY_BYTES = 64'd4;

  // one result item of the parser
  typedef struct packed {
    logic                header_done;
    logic                body_valid;
    logic [BYTE_W-1:0]   body_byte;
    logic                frame_close;
    logic                fin_bit;
    logic [OPCODE_W-1:0] opcode;
    logic                is_masked;
    logic [LEN_W-1:0]    payload_length;
  } wsdf_result_t;

endpackage

// ===== rtl/core/wsdf_parser.sv =====
// frame header state machine, length countdown and payload unmasking
module wsdf_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic [wsdf_pkg::BYTE_W-1:0]   stream_byte,
  output wsdf_pkg::wsdf_result_t        result
);
  import wsdf_pkg::*;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_HEAD   = 3'd1,
    PH_LENGTH = 3'd2,
    PH_MASK   = 3'd3,
    PH_BODY   = 3'd4
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic                fin_r, fin_nxt;
  logic [OPCODE_W-1:0] opcode_r, opcode_nxt;
  logic                masked_r, masked_nxt;
  logic [LEN_W-1:0]    length_r, length_nxt;
  logic [LEN_W-1:0]    needed_r, needed_nxt;
  logic [BYTE_W-1:0]   key_r [4];
  logic [BYTE_W-1:0]   key_nxt [4];
  logic [1:0]          mphase_r, mphase_nxt;

  logic [6:0]          len7;
  logic [LEN_W-1:0]    needed_dec;
  logic                needed_last;
  logic [1:0]          key_idx;
  logic [LEN_W-1:0]    ext_length;
  logic                hdr, valid, fend;
  logic [BYTE_W-1:0]   data;

  // countdown that stops at zero
  assign len7        = stream_byte[6:0];
  assign needed_dec  = (needed_r != '0) ? needed_r - 64'd1 : '0;
  assign needed_last = (needed_dec == '0);
  assign key_idx     = 2'(3'd4 - needed_r[2:0]);
  assign ext_length  = {length_r[LEN_W-BYTE_W-1:0], stream_byte};

  // next state and result for the byte in the input register
  always_comb begin
    phase_nxt  = phase_r;
    fin_nxt    = fin_r;
    opcode_nxt = opcode_r;
    masked_nxt = masked_r;
    length_nxt = length_r;
    needed_nxt = needed_r;
    key_nxt    = key_r;
    mphase_nxt = mphase_r;
    hdr   = 1'b0;
    valid = 1'b0;
    fend  = 1'b0;
    data  = '0;
    case (phase_r)
      PH_HEAD: begin
        masked_nxt = stream_byte[7];
        if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
          needed_nxt = (len7 == LEN_EXT64) ? EXT64_BYTES : EXT16_BYTES;
          length_nxt = '0;
          phase_nxt  = PH_LENGTH;
        end else begin
          length_nxt = {{(LEN_W-7){1'b0}}, len7};
          if (stream_byte[7]) begin
            phase_nxt  = PH_MASK;
            needed_nxt = MASK_KEY_BYTES;
          end else begin
            hdr = 1'b1;
            if (len7 != '0) begin
              phase_nxt  = PH_BODY;
              needed_nxt = {{(LEN_W-7){1'b0}}, len7};
            end else begin
              fend      = 1'b1;
              phase_nxt = PH_START;
            end
          end
        end
      end
      PH_LENGTH: begin
        length_nxt = ext_length;
        needed_nxt = needed_dec;
        if (needed_last) begin
          if (masked_r) begin
            phase_nxt  = PH_MASK;
            needed_nxt = MASK_KEY_BYTES;
          end else begin
            hdr = 1'b1;
            if (ext_length != '0) begin
              phase_nxt  = PH_BODY;
              needed_nxt = ext_length;
            end else begin
              fend      = 1'b1;
              phase_nxt = PH_START;
            end
          end
        end
      end
      PH_MASK: begin
        key_nxt[key_idx] = stream_byte;
        needed_nxt       = needed_dec;
        if (needed_last) begin
          hdr = 1'b1;
          if (length_r != '0) begin
            phase_nxt  = PH_BODY;
            needed_nxt = length_r;
          end else begin
            fend      = 1'b1;
            phase_nxt = PH_START;
          end
        end
      end
      PH_BODY: begin
        valid      = 1'b1;
        data       = masked_r ? (stream_byte ^ key_r[mphase_r]) : stream_byte;
        mphase_nxt = mphase_r + 2'd1;
        needed_nxt = needed_dec;
        if (needed_last) begin
          fend      = 1'b1;
          phase_nxt = PH_START;
        end
      end
      default: begin
        // start of frame, unused codes land here too
        fin_nxt    = stream_byte[7];
        opcode_nxt = stream_byte[OPCODE_W-1:0];
        masked_nxt = 1'b0;
        length_nxt = '0;
        mphase_nxt = '0;
        phase_nxt  = PH_HEAD;
      end
    endcase
  end

  // result reflects the state as updated by this byte
  always_comb begin
    result.header_done    = hdr;
    result.body_valid     = valid;
    result.body_byte      = data;
    result.frame_close    = fend;
    result.fin_bit        = fin_nxt;
    result.opcode         = opcode_nxt;
    result.is_masked      = masked_nxt;
    result.payload_length = length_nxt;
  end

  // parser state, advances once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      fin_r    <= 1'b0;
      opcode_r <= '0;
      masked_r <= 1'b0;
      length_r <= '0;
      needed_r <= '0;
      key_r    <= '{default: '0};
      mphase_r <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      fin_r    <= fin_nxt;
      opcode_r <= opcode_nxt;
      masked_r <= masked_nxt;
      length_r <= length_nxt;
      needed_r <= needed_nxt;
      key_r    <= key_nxt;
      mphase_r <= mphase_nxt;
    end
  end

endmodule

// ===== rtl/core/websocket_frame_deframer_top.sv =====
// WebSocket frame deframer: takes one stream byte per item and gives one result item
// per byte. It decodes FIN, opcode, mask flag and the 7-, 16- or 64-bit payload
// length, collects the 4-byte mask key and unmasks payload bytes; tlast marks the
// byte that ends a frame, and an empty frame raises header_done and tlast on its
// last header byte. Throughput is one item per cycle with no gaps while out_tready
// stays high; out_tvalid for a result rises once its byte has passed the input
// register and then the result register. The path that sets the clock is the
// 64-bit remaining-byte countdown (decrement and zero compare) between those two
// registers. While a result waits for out_tready, one more byte is taken into the
// input register and then in_tready drops; with both registers full, in_tready
// follows out_tready in the same cycle.
module websocket_frame_deframer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [wsdf_pkg::BYTE_W-1:0]      in_tdata,   // [7:0] stream_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] body_byte, [8] fin_bit, [12:9] opcode, [13] is_masked,
  // [77:14] payload_length, [79:78] zero
  output logic [wsdf_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [wsdf_pkg::OUT_TUSER_W-1:0] out_tuser,  // [0] header_done, [1] body_valid
  output logic                             out_tlast   // frame_close
);
  import wsdf_pkg::*;
`include "websocket_frame_deframer_top_defines.svh"

  logic              in_v_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_v_r;
  wsdf_result_t      out_res_r;
  wsdf_result_t      res;
  logic              adv;

  // input register moves forward when the result register is free
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  wsdf_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (adv),
    .stream_byte (in_byte_r),
    .result      (res)
  );

  // input and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  // result item packing
  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_res_r.payload_length, out_res_r.is_masked,
                       out_res_r.opcode, out_res_r.fin_bit, out_res_r.body_byte};
  assign out_tuser  = {out_res_r.body_valid, out_res_r.header_done};
  assign out_tlast  = out_res_r.frame_close;

  // a header byte is never a payload byte
  `WSDF_ASSERT_IMPL(a_hdr_not_body, out_v_r,
                    !(out_res_r.header_done && out_res_r.body_valid),
                    "header_done together with body_valid")
  // non-payload items carry a zero data byte
  `WSDF_ASSERT_IMPL(a_body_zero, out_v_r && !out_res_r.body_valid,
                    out_res_r.body_byte == '0, "body_byte nonzero outside payload")
  // a frame end without payload only comes from an empty frame
  `WSDF_ASSERT_IMPL(a_empty_end, out_v_r && out_res_r.frame_close && !out_res_r.body_valid,
                    out_res_r.header_done && out_res_r.payload_length == '0,
                    "frame end outside payload without empty header")
  // a byte that advances always shows up as a result next cycle
  `WSDF_ASSERT_NEXT(a_adv_result, adv, out_v_r, "advanced item not presented")

endmodule

// ===== dv/tb_websocket_frame_deframer_top.sv =====
// self-checking testbench for the websocket frame deframer top level
`timescale 1ns / 100ps

module tb_websocket_frame_deframer_top;
  import wsdf_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1700;
  localparam int MAX_REPORTS  = 10;

  // parser phases of the predictor
  typedef enum logic [2:0] {
    PH_FIRST,
    PH_LEN_BYTE,
    PH_EXT_LEN,
    PH_MASK_KEY,
    PH_PAYLOAD
  } parse_phase_t;

  // how the payload length is carried in the header
  typedef enum int {
    LEN_SHORT,
    LEN_WIDE16,
    LEN_WIDE64
  } len_form_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  // predictor state
  parse_phase_t      ph;
  logic              fin_q;
  logic [3:0]        opc_q;
  logic              masked_q;
  logic [LEN_W-1:0]  len_q;
  logic [LEN_W-1:0]  need_q;
  logic [7:0]        key_q [0:3];
  logic [1:0]        mphase_q;

  wsdf_result_t expected_results [$];

  // bookkeeping
  int burst_left;
  int items_sent;
  int input_stalls;
  int frames_ended;
  int payload_bytes;
  int results_checked;
  int fail_count;
  int cycle_count;

  // receiver state
  int          hold_reqs;
  int          hold_seen;
  int          hold_left;
  int          pat_left;
  logic [15:0] rdy_pat;
  wsdf_result_t got;
  wsdf_result_t want;

  websocket_frame_deframer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // header finished on the length path: mask key next, payload, or empty frame done
  function automatic void finish_header(inout wsdf_result_t r);
    if (masked_q) begin
      ph = PH_MASK_KEY;
      need_q = MASK_KEY_BYTES;
    end else begin
      r.header_done = 1'b1;
      if (len_q != '0) begin
        ph = PH_PAYLOAD;
        need_q = len_q;
      end else begin
        r.frame_close = 1'b1;
        ph = PH_FIRST;
      end
    end
  endfunction

  // advance the parser by one stream byte and return the result it yields
  function automatic wsdf_result_t parse_byte(input logic [7:0] b);
    wsdf_result_t r;
    logic [6:0]   len7;
    logic [1:0]   kidx;
    r = '0;
    len7 = b[6:0];
    case (ph)
      PH_LEN_BYTE: begin
        masked_q = b[7];
        if (len7 >= LEN_EXT16) begin
          need_q = (len7 == LEN_EXT64) ? EXT64_BYTES : EXT16_BYTES;
          len_q = '0;
          ph = PH_EXT_LEN;
        end else begin
          len_q = {57'd0, len7};
          finish_header(r);
        end
      end
      PH_EXT_LEN: begin
        len_q = {len_q[LEN_W-9:0], b};
        if (need_q != '0) need_q = need_q - 64'd1;
        if (need_q == '0) finish_header(r);
      end
      PH_MASK_KEY: begin
        kidx = 2'(3'd4 - need_q[2:0]);
        key_q[kidx] = b;
        if (need_q != '0) need_q = need_q - 64'd1;
        if (need_q == '0) begin
          r.header_done = 1'b1;
          if (len_q != '0) begin
            ph = PH_PAYLOAD;
            need_q = len_q;
          end else begin
            r.frame_close = 1'b1;
            ph = PH_FIRST;
          end
        end
      end
      PH_PAYLOAD: begin
        r.body_valid = 1'b1;
        r.body_byte = masked_q ? (b ^ key_q[mphase_q]) : b;
        mphase_q = mphase_q + 2'd1;
        if (need_q != '0) need_q = need_q - 64'd1;
        if (need_q == '0) begin
          r.frame_close = 1'b1;
          ph = PH_FIRST;
        end
      end
      default: begin
        fin_q = b[7];
        opc_q = b[3:0];
        masked_q = 1'b0;
        len_q = '0;
        mphase_q = 2'd0;
        ph = PH_LEN_BYTE;
      end
    endcase
    r.fin_bit = fin_q;
    r.opcode = opc_q;
    r.is_masked = masked_q;
    r.payload_length = len_q;
    return r;
  endfunction

  function automatic string fmt_result(input wsdf_result_t r);
    return $sformatf("hdr=%0b body=%0b byte=%02h end=%0b fin=%0b op=%h mask=%0b len=%016h",
                     r.header_done, r.body_valid, r.body_byte, r.frame_close, r.fin_bit,
                     r.opcode, r.is_masked, r.payload_length);
  endfunction

  // send one byte, with bursts and random gaps between them
  task automatic send_byte(input logic [7:0] b);
    wsdf_result_t r;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) begin
      input_stalls++;
      @(posedge clk);
    end
    r = parse_byte(b);
    expected_results.push_back(r);
    if (r.frame_close) frames_ended++;
    if (r.body_valid) payload_bytes++;
    burst_left--;
    items_sent++;
  endtask

  // one frame: header, optional extended length and mask key, then body_cnt payload bytes
  task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] opc,
                            input logic masked, input len_form_t form,
                            input logic [63:0] len, input int body_cnt);
    logic [7:0] key [0:3];
    logic [6:0] len7;
    int         nbytes;
    for (int i = 0; i < 4; i++) key[i] = 8'($urandom);
    case (form)
      LEN_WIDE16: begin len7 = LEN_EXT16; nbytes = 2; end
      LEN_WIDE64: begin len7 = LEN_EXT64; nbytes = 8; end
      default:    begin len7 = len[6:0];  nbytes = 0; end
    endcase
    send_byte({fin, rsv, opc});
    send_byte({masked, len7});
    for (int i = nbytes - 1; i >= 0; i--) send_byte(len[8*i +: 8]);
    if (masked) for (int i = 0; i < 4; i++) send_byte(key[i]);
    for (int i = 0; i < body_cnt; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  // stop sending until every expected result has come back
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // empty frames in the short and 16-bit header forms, raw payload, rsv bits set, odd opcodes
  task automatic test_directed();
    send_frame(1'b1, 3'd0, 4'h9, 1'b0, LEN_SHORT, 64'd0, 0);
    send_frame(1'b1, 3'd7, 4'hF, 1'b1, LEN_SHORT, 64'd0, 0);
    send_frame(1'b0, 3'd0, 4'h0, 1'b0, LEN_SHORT, 64'd1, 1);
    send_frame(1'b1, 3'd5, 4'h2, 1'b0, LEN_WIDE16, 64'd0, 0);
    send_frame(1'b0, 3'd2, 4'hA, 1'b0, LEN_WIDE64, 64'd1, 1);
  endtask

  // random well-formed frames, including non-minimal and empty extended lengths
  task automatic test_random_frames();
    len_form_t   form;
    logic [63:0] len;
    int          pick;
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        form = LEN_SHORT;
        len = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(0, 125))
                                          : 64'($urandom_range(0, 12));
      end else if (pick <= 8) begin
        form = LEN_WIDE16;
        len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 400))
                                          : 64'($urandom_range(0, 24));
      end else begin
        form = LEN_WIDE64;
        len = 64'($urandom_range(0, 24));
      end
      send_frame(1'($urandom), ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'd0,
                 4'($urandom), 1'($urandom), form, len, int'(len));
    end
  endtask

  // long receiver hold-off while bytes keep coming, so the input side stalls
  task automatic test_backpressure();
    hold_reqs <= hold_reqs + 1;
    burst_left = 200;
    while (items_sent < RANDOM_ITEMS + 80)
      send_frame(1'b1, 3'd0, 4'h2, 1'b1, LEN_SHORT, 64'd10, 10);
    wait_results_drained();
  endtask

  // sender pauses mid-run until the pipeline is empty, then resumes
  task automatic test_pause_drain();
    send_frame(1'b0, 3'd0, 4'h1, 1'b1, LEN_WIDE16, 64'd7, 7);
    wait_results_drained();
    send_frame(1'b1, 3'd0, 4'h0, 1'b1, LEN_SHORT, 64'd5, 5);
    wait_results_drained();
  endtask

  // maximum 64-bit length; the frame stays open for the rest of the run
  task automatic test_max_length();
    send_frame(1'b1, 3'd0, 4'h2, 1'b1, LEN_WIDE64, 64'hFFFF_FFFF_FFFF_FFFF, 32);
  endtask

  // result checker and ready pattern
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.header_done    = out_tuser[0];
      got.body_valid     = out_tuser[1];
      got.body_byte      = out_tdata[7:0];
      got.fin_bit        = out_tdata[8];
      got.opcode         = out_tdata[12:9];
      got.is_masked      = out_tdata[13];
      got.payload_length = out_tdata[77:14];
      got.frame_close    = out_tlast;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result item: %s", fmt_result(got));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got !== want || out_tdata[79:78] !== 2'b00) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("mismatch at result %0d, pad=%b", results_checked, out_tdata[79:78]);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
          end
        end
      end
    end

    // long hold-off on request, otherwise a rotating stall pattern
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        case ($urandom_range(0, 2))
          0:       rdy_pat = '1;
          1:       rdy_pat = 16'($urandom);
          default: rdy_pat = 16'($urandom) | 16'($urandom);
        endcase
        pat_left = 32;
      end
      out_tready <= rdy_pat[0];
      rdy_pat = {rdy_pat[0], rdy_pat[15:1]};
      pat_left--;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("FAIL websocket_frame_deframer_top");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    ph = PH_FIRST;
    fin_q = 1'b0;
    opc_q = '0;
    masked_q = 1'b0;
    len_q = '0;
    need_q = '0;
    for (int i = 0; i < 4; i++) key_q[i] = '0;
    mphase_q = '0;
    burst_left = 0;
    items_sent = 0;
    input_stalls = 0;
    frames_ended = 0;
    payload_bytes = 0;
    results_checked = 0;
    fail_count = 0;
    cycle_count = 0;
    hold_reqs = 0;
    hold_seen = 0;
    hold_left = 0;
    pat_left = 0;
    rdy_pat = '1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_frames();
    test_backpressure();
    test_pause_drain();
    test_max_length();

    wait_results_drained();
    repeat (8) @(posedge clk);

    if (expected_results.size() != 0) begin
      fail_count += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end
    $display("sent %0d bytes: %0d frames closed, %0d payload bytes, %0d results checked",
             items_sent, frames_ended, payload_bytes, results_checked);
    $display("input stalled %0d cycles under back-pressure, %0d failures",
             input_stalls, fail_count);
    if (fail_count == 0) begin
      $display("PASS websocket_frame_deframer_top");
    end else begin
      $display("FAIL websocket_frame_deframer_top");
    end
    $finish;
  end

endmodule

// ===== websocket_frame_deframer_top.f =====
+incdir+rtl/core
rtl/core/wsdf_pkg.sv
rtl/core/wsdf_parser.sv
rtl/core/websocket_frame_deframer_top.sv
dv/tb_websocket_frame_deframer_top.sv
